FILE: sv/rbq_pkg.sv
// Shared types and constants of the reset button qualifier.
// Holds the configuration record, the controller/datapath command and status
// structs, and the register map. Depends on nothing.
`default_nettype none

package rbq_pkg;

  localparam int TickW     = 63;  // timestamp width
  localparam int CfgW      = 32;  // width of the 32-bit tick registers
  localparam int MinW      = 6;   // demo minutes width
  localparam int MinProdW  = MinW + 6;          // minutes times sixty
  localparam int ProdW     = MinProdW + CfgW;   // minutes times sixty times rate
  localparam int FireW     = TickW + 1;         // demo start time, may exceed 63 bits
  localparam int ApbW      = 64;
  localparam int AddrW     = 6;
  localparam int IdxW      = 3;
  localparam int DivSteps  = 62;  // quotient bits 62 down to 1
  localparam int CntW      = 6;
  localparam int SecPerMin = 60;

  typedef logic [IdxW-1:0] reg_idx_t;

  localparam reg_idx_t RegQualify   = 3'd0;
  localparam reg_idx_t RegHold      = 3'd1;
  localparam reg_idx_t RegTickRate  = 3'd2;
  localparam reg_idx_t RegDemoMin   = 3'd3;
  localparam reg_idx_t RegStartTime = 3'd4;

  localparam logic [CfgW-1:0] QualifyReset  = 32'd4050;
  localparam logic [CfgW-1:0] HoldReset     = 32'd1620000;
  localparam logic [CfgW-1:0] TickRateReset = 32'd40500000;

  typedef struct packed {
    logic [CfgW-1:0]  qualify_ticks;
    logic [CfgW-1:0]  release_hold_ticks;
    logic [CfgW-1:0]  ticks_per_second;
    logic [MinW-1:0]  demo_minutes;
    logic [TickW-1:0] start_time;
  } rbq_cfg_t;

  typedef struct packed {
    logic load;      // capture the input transaction
    logic eval;      // run the debounce update and the demo product
    logic fire;      // form the demo start time
    logic div_init;  // load the divider with the elapsed ticks
    logic div_step;  // one restoring division step
    logic out_load;  // move the result into the output register
    logic use_demo;  // result comes from the demo toggle
  } rbq_cmd_t;

  typedef struct packed {
    logic is_intr;
    logic demo_on;
    logic fire_before_now;
  } rbq_sts_t;

endpackage

`default_nettype wire

FILE: sv/rbq_if.sv
// Valid/ready channel interfaces for the input and result transactions.
// Field widths come from rbq_pkg.
`default_nettype none

interface rbq_in_if import rbq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic             button_down;
  logic [TickW-1:0] now_ticks;

  modport source(output valid, kind, button_down, now_ticks, input ready);
  modport sink(input valid, kind, button_down, now_ticks, output ready);
endinterface

interface rbq_out_if import rbq_pkg::*; ();
  logic valid;
  logic ready;
  logic pressed_state;
  logic reset_event;

  modport source(output valid, pressed_state, reset_event, input ready);
  modport sink(input valid, pressed_state, reset_event, output ready);
endinterface

`default_nettype wire

FILE: sv/rbq_regs.sv
// APB-style configuration register file of the reset button qualifier.
// Depends on rbq_pkg for the register map and the configuration record.
`default_nettype none

module rbq_regs import rbq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [ApbW-1:0]  pwdata,
  output logic [ApbW-1:0]  prdata,
  output logic             pready,
  output rbq_cfg_t         cfg_o
);

  rbq_cfg_t cfg_q;
  reg_idx_t idx;
  logic     wr;

  assign idx    = paddr[AddrW-1:AddrW-IdxW];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.qualify_ticks      <= QualifyReset;
      cfg_q.release_hold_ticks <= HoldReset;
      cfg_q.ticks_per_second   <= TickRateReset;
      cfg_q.demo_minutes       <= '0;
      cfg_q.start_time         <= '0;
    end else if (wr) begin
      case (idx)
        RegQualify:   cfg_q.qualify_ticks      <= pwdata[CfgW-1:0];
        RegHold:      cfg_q.release_hold_ticks <= pwdata[CfgW-1:0];
        RegTickRate:  cfg_q.ticks_per_second   <= pwdata[CfgW-1:0];
        RegDemoMin:   cfg_q.demo_minutes       <= pwdata[MinW-1:0];
        RegStartTime: cfg_q.start_time         <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegQualify:   prdata = ApbW'(cfg_q.qualify_ticks);
      RegHold:      prdata = ApbW'(cfg_q.release_hold_ticks);
      RegTickRate:  prdata = ApbW'(cfg_q.ticks_per_second);
      RegDemoMin:   prdata = ApbW'(cfg_q.demo_minutes);
      RegStartTime: prdata = ApbW'(cfg_q.start_time);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/rbq_ctrl.sv
// Sequencing state machine of the reset button qualifier.
// Drives the datapath by rbq_cmd_t and reads rbq_sts_t; depends on rbq_pkg.
`default_nettype none

module rbq_ctrl import rbq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  rbq_sts_t sts_i,
  output rbq_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_FIRE = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            demo_sel_q, demo_sel_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    demo_sel_d = demo_sel_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_FIRE;
      end
      S_FIRE: begin
        cmd_o.fire = 1'b1;
        state_d    = S_CMP;
      end
      S_CMP: begin
        if (!sts_i.is_intr && sts_i.demo_on && sts_i.fire_before_now) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = CntW'(DivSteps - 1);
          demo_sel_d     = 1'b1;
          state_d        = S_DIV;
        end else begin
          demo_sel_d = 1'b0;
          state_d    = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DONE: begin
        // The result waits here until the output register is free.
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.use_demo = demo_sel_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      demo_sel_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      demo_sel_q  <= demo_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EVAL)
    else $error("accepted transaction did not start evaluation");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && cnt_q == '0 |=> state_q == S_DONE)
    else $error("division did not end after its last step");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("pending result dropped while receiver stalled");
`endif

endmodule

`default_nettype wire

FILE: sv/rbq_datapath.sv
// Datapath of the reset button qualifier: debounce state, demo start time,
// bit-serial restoring divider and the output register. Depends on rbq_pkg.
`default_nettype none

module rbq_datapath import rbq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rbq_cfg_t         cfg_i,
  input  logic             kind_i,
  input  logic             button_down_i,
  input  logic [TickW-1:0] now_ticks_i,
  input  rbq_cmd_t         cmd_i,
  output rbq_sts_t         sts_o,
  output logic             pressed_state_o,
  output logic             reset_event_o
);

  // Captured transaction.
  logic             kind_q, down_q;
  logic [TickW-1:0] now_q;

  // Debounce state.
  logic             is_down_q, is_down_d;
  logic             last_q, last_d;
  logic [TickW-1:0] rel_q, rel_d;
  logic [TickW-1:0] press_q, press_d;
  logic             st_q, st_d;

  // Demo timing.
  logic [CfgW-1:0]     tps_eff;
  logic [MinProdW-1:0] min_x60;
  logic [ProdW-1:0]    prod_q;
  logic [FireW-1:0]    fire_q;
  logic [FireW:0]      now_minus_fire;
  logic [TickW-1:0]    dvd_q;
  logic [CfgW-1:0]     rem_q;
  logic [CfgW:0]       rem_shift, rem_sub;
  logic                ge;
  logic                qbit_q;

  logic             pressed_q, event_q;
  logic [TickW:0]   press_diff, rel_diff;
  logic             press_qual, rel_any, rel_hold;

  assign tps_eff = (cfg_i.ticks_per_second == '0) ? CfgW'(1) : cfg_i.ticks_per_second;
  assign min_x60 = MinProdW'(cfg_i.demo_minutes) * MinProdW'(SecPerMin);

  assign press_diff = {1'b0, now_q} - {1'b0, press_q};
  assign rel_diff   = {1'b0, now_q} - {1'b0, rel_q};
  // A timestamp earlier than the press counts as not yet qualified.
  assign press_qual = !press_diff[TickW] &&
                      (press_diff[TickW-1:0] > TickW'(cfg_i.qualify_ticks));
  assign rel_any    = rel_q != '0;
  // A timestamp earlier than the release counts as still within the hold.
  assign rel_hold   = rel_any && (rel_diff[TickW] ||
                      (rel_diff[TickW-1:0] < TickW'(cfg_i.release_hold_ticks)));

  always_comb begin
    is_down_d = is_down_q;
    last_d    = last_q;
    rel_d     = rel_q;
    press_d   = press_q;
    st_d      = 1'b0;
    if (kind_q) begin
      press_d = now_q;
      if (down_q) begin
        is_down_d = 1'b1;
        last_d    = 1'b1;
      end
    end else begin
      if (down_q) begin
        if (!is_down_q) begin
          is_down_d = 1'b1;
          st_d      = rel_any;
          press_d   = now_q;
        end else begin
          st_d = rel_any || press_qual;
        end
      end else if (is_down_q) begin
        is_down_d = 1'b0;
        st_d      = last_q;
        rel_d     = last_q ? now_q : '0;
      end else if (rel_hold) begin
        st_d = 1'b1;
      end else begin
        st_d  = 1'b0;
        rel_d = '0;
      end
      last_d = st_d;
    end
  end

  assign now_minus_fire = {2'b00, now_q} - {1'b0, fire_q};

  assign sts_o.is_intr         = kind_q;
  assign sts_o.demo_on         = cfg_i.demo_minutes != '0;
  assign sts_o.fire_before_now = !now_minus_fire[FireW] &&
                                 (now_minus_fire[FireW-1:0] != '0);

  // One quotient bit per step; only the bit worth two seconds is kept.
  assign rem_shift = {rem_q, dvd_q[TickW-1]};
  assign rem_sub   = rem_shift - {1'b0, tps_eff};
  assign ge        = rem_shift >= {1'b0, tps_eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_down_q <= 1'b0;
      last_q    <= 1'b0;
      rel_q     <= '0;
      press_q   <= '0;
    end else if (cmd_i.eval) begin
      is_down_q <= is_down_d;
      last_q    <= last_d;
      rel_q     <= rel_d;
      press_q   <= press_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      down_q <= button_down_i;
      now_q  <= now_ticks_i;
    end
    if (cmd_i.eval) begin
      st_q   <= st_d;
      prod_q <= ProdW'(min_x60) * ProdW'(tps_eff);
    end
    if (cmd_i.fire) begin
      fire_q <= {1'b0, cfg_i.start_time} + FireW'(prod_q);
    end
    if (cmd_i.div_init) begin
      dvd_q <= now_minus_fire[TickW-1:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[TickW-2:0], 1'b0};
      rem_q  <= ge ? rem_sub[CfgW-1:0] : rem_shift[CfgW-1:0];
      qbit_q <= ge;
    end
    if (cmd_i.out_load) begin
      pressed_q <= cmd_i.use_demo ? ~qbit_q : (st_q & ~kind_q);
      event_q   <= kind_q & down_q;
    end
  end

  assign pressed_state_o = pressed_q;
  assign reset_event_o   = event_q;

`ifndef ASSERT_OFF
  a_intr_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && kind_q |=> !pressed_state_o && reset_event_o == $past(down_q))
    else $error("interrupt result fields wrong");

  a_intr_marks_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval && kind_q && down_q |=> is_down_q && last_q)
    else $error("interrupt with button down did not mark it pressed");

  a_poll_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval && !kind_q && !down_q |=> !is_down_q)
    else $error("poll with button up left it marked down");
`endif

endmodule

`default_nettype wire

FILE: sv/reset_button_qualifier_top.sv
// Reset button qualifier: debounces a reset push button, reports the
// qualified state to polls and confirms interrupt events.
//
// Channels: in_i carries one transaction per poll (kind 0) or interrupt
// event (kind 1) with the raw level and a 63-bit tick timestamp; out_o
// returns exactly one result per input transaction, in order. Both use
// valid/ready; a transaction moves when valid and ready are high at a
// rising edge. The APB port sets the five registers at byte address 8*i.
// An accepted item passes the states EVAL, FIRE and CMP to DONE; a poll in
// active demo mode also passes DIV, where a restoring divider works out the
// two-second bit of the elapsed seconds. One item is in work at a time, so
// the next is taken only once the last result is loaded for output.
// The output register holds a result while out_o.ready is low; the next
// item is accepted meanwhile and waits after evaluation for the register.
// Reset (rst_ni low) restores register defaults and clears the button
// state; no clearing pass is needed afterwards.
// Depends on rbq_pkg, rbq_if, rbq_regs, rbq_ctrl and rbq_datapath.
`default_nettype none

module reset_button_qualifier_top import rbq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  rbq_in_if.sink           in_i,
  rbq_out_if.source        out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [ApbW-1:0]  pwdata,
  output logic [ApbW-1:0]  prdata,
  output logic             pready
);

  rbq_cfg_t cfg;
  rbq_cmd_t cmd;
  rbq_sts_t sts;
  logic     in_ready;
  logic     out_valid;
  logic     pressed_state;
  logic     reset_event;

  rbq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rbq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .kind_i          (in_i.kind),
    .button_down_i   (in_i.button_down),
    .now_ticks_i     (in_i.now_ticks),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pressed_state_o (pressed_state),
    .reset_event_o   (reset_event)
  );

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid;
  assign out_o.pressed_state = pressed_state;
  assign out_o.reset_event   = reset_event;

endmodule

`default_nettype wire

FILE: bench/tb_reset_button_qualifier_top.sv
`timescale 1ns / 100ps
// Self-checking bench for reset_button_qualifier_top: drives polls and interrupt events,
// predicts each qualified report and compares it with the result channel.
// Depends on rbq_pkg, rbq_if and the reset_button_qualifier_top RTL.

module tb_reset_button_qualifier_top;
  import rbq_pkg::*;

  localparam logic KindPoll = 1'b0;
  localparam logic KindIrq  = 1'b1;

  localparam reg_idx_t RegBeyondMap = 3'd5;
  localparam reg_idx_t RegTopUnused = 3'd7;

  localparam logic [TickW-1:0] MaxTick = '1;

  localparam int unsigned CycleLimit  = 1500000;
  localparam int unsigned DrainCycles = 100;

  typedef struct packed {
    logic             kind;
    logic             button_down;
    logic [TickW-1:0] now_ticks;
  } button_sample_t;

  typedef struct packed {
    logic pressed_state;
    logic reset_event;
  } button_report_t;

  typedef enum logic [1:0] {StallNone, StallRandom, StallLong} stall_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [ApbW-1:0]  pwdata;
  logic [ApbW-1:0]  prdata;
  logic             pready;

  rbq_in_if  button_in();
  rbq_out_if report_out();

  reset_button_qualifier_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (button_in),
    .out_o   (report_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the register file and of the debounce state.
  rbq_cfg_t         shadow_cfg;
  logic             held_down;
  logic             shown_pressed;
  logic [TickW-1:0] release_stamp;
  logic [TickW-1:0] press_stamp;

  button_sample_t samples_to_send[$];
  button_report_t reports_due[$];

  logic [TickW-1:0] tick_cursor;
  logic [TickW-1:0] time_anchor;

  int unsigned samples_made;
  int unsigned polls_sent;
  int unsigned irqs_sent;
  int unsigned demo_polls;
  int unsigned reports_checked;
  int unsigned reg_writes;
  int unsigned settings_run;
  int unsigned error_count;
  int unsigned cycle_count;

  int unsigned burst_left;
  int unsigned gap_left;
  stall_mode_e stall_mode;
  int unsigned stall_mode_left;
  int unsigned stall_run;
  button_sample_t next_sample;
  button_report_t want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] tick_rate();
    logic [63:0] rate;
    rate = shadow_cfg.ticks_per_second;
    if (rate == 0) rate = 64'd1;
    return rate;
  endfunction

  // Tick at which the demo toggling starts; may exceed the 63-bit time range.
  function automatic logic [63:0] demo_start_tick();
    logic [63:0] mins;
    logic [63:0] base;
    mins = shadow_cfg.demo_minutes;
    base = shadow_cfg.start_time;
    return base + mins * SecPerMin * tick_rate();
  endfunction

  function automatic button_report_t qualify_button(input logic kind, input logic down,
                                                    input logic [TickW-1:0] now);
    button_report_t rep;
    logic           st;
    logic [63:0]    fire_at;
    logic [63:0]    now_wide;
    logic [63:0]    secs;
    rep = '0;
    if (kind == KindIrq) begin
      press_stamp = now;
      if (down) begin
        held_down = 1'b1;
        shown_pressed = 1'b1;
      end
      rep.reset_event = down;
      return rep;
    end
    if (down) begin
      if (!held_down) begin
        held_down = 1'b1;
        st = (release_stamp != 0);
        press_stamp = now;
      end else begin
        st = (release_stamp != 0) ||
             (now >= press_stamp && (now - press_stamp) > shadow_cfg.qualify_ticks);
      end
    end else if (held_down) begin
      held_down = 1'b0;
      st = shown_pressed;
      release_stamp = st ? now : '0;
    end else if (release_stamp != 0 &&
                 (now < release_stamp ||
                  (now - release_stamp) < shadow_cfg.release_hold_ticks)) begin
      st = 1'b1;
    end else begin
      st = 1'b0;
      release_stamp = '0;
    end
    // The stored state stays the qualified one even while demo toggling overrides it.
    shown_pressed = st;
    if (shadow_cfg.demo_minutes != 0) begin
      fire_at = demo_start_tick();
      now_wide = now;
      if (fire_at < now_wide) begin
        secs = (now_wide - fire_at) / tick_rate();
        st = (secs[1] == 1'b0);
        demo_polls++;
      end
    end
    rep.pressed_state = st;
    return rep;
  endfunction

  // Sender: bursts of transactions separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      button_in.valid <= 1'b0;
    end else begin
      if (button_in.valid && button_in.ready) begin
        reports_due.push_back(qualify_button(button_in.kind, button_in.button_down,
                                             button_in.now_ticks));
        if (button_in.kind == KindIrq) irqs_sent++;
        else polls_sent++;
      end
      if (!button_in.valid || button_in.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          button_in.valid <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          next_sample = samples_to_send.pop_front();
          button_in.valid       <= 1'b1;
          button_in.kind        <= next_sample.kind;
          button_in.button_down <= next_sample.button_down;
          button_in.now_ticks   <= next_sample.now_ticks;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          button_in.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls on a pattern that changes now and then.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      report_out.ready <= 1'b0;
    end else begin
      if (report_out.valid && report_out.ready) begin
        if (reports_due.size() == 0) begin
          $display("%0t: result with no transaction pending: pressed_state %0b reset_event %0b",
                   $time, report_out.pressed_state, report_out.reset_event);
          error_count++;
        end else begin
          want = reports_due.pop_front();
          if (report_out.pressed_state !== want.pressed_state) begin
            $display("%0t: pressed_state expected %0b, actual %0b", $time,
                     want.pressed_state, report_out.pressed_state);
            error_count++;
          end
          if (report_out.reset_event !== want.reset_event) begin
            $display("%0t: reset_event expected %0b, actual %0b", $time,
                     want.reset_event, report_out.reset_event);
            error_count++;
          end
          reports_checked++;
        end
      end
      if (stall_mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        stall_mode_left = $urandom_range(50, 400);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        StallNone: begin
          report_out.ready <= 1'b1;
        end
        StallRandom: begin
          report_out.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (stall_run != 0) begin
            stall_run--;
            report_out.ready <= 1'b0;
          end else begin
            report_out.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_run = $urandom_range(5, 30);
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, reports_due.size());
      $display("reset_button_qualifier_top test failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [ApbW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegQualify:   shadow_cfg.qualify_ticks      = value[CfgW-1:0];
      RegHold:      shadow_cfg.release_hold_ticks = value[CfgW-1:0];
      RegTickRate:  shadow_cfg.ticks_per_second   = value[CfgW-1:0];
      RegDemoMin:   shadow_cfg.demo_minutes       = value[MinW-1:0];
      RegStartTime: shadow_cfg.start_time         = value[TickW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic wait_for_drain();
    while (samples_to_send.size() != 0 || button_in.valid || reports_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic queue_sample(input logic kind, input logic down,
                              input logic [TickW-1:0] stamp);
    button_sample_t s;
    s.kind = kind;
    s.button_down = down;
    s.now_ticks = stamp;
    samples_to_send.push_back(s);
    samples_made++;
  endtask

  // Step sizes cluster around the qualify and hold windows and the tick rate.
  function automatic logic [TickW-1:0] tick_step();
    logic [63:0] q;
    logic [63:0] h;
    logic [63:0] step;
    q = shadow_cfg.qualify_ticks;
    h = shadow_cfg.release_hold_ticks;
    case ($urandom_range(0, 6))
      0: step = $urandom_range(0, 3);
      1: step = q + $urandom_range(0, 2) - 64'd1;
      2: step = q * $urandom_range(0, 200) / 100;
      3: step = h + $urandom_range(0, 2) - 64'd1;
      4: step = h * $urandom_range(0, 200) / 100;
      5: step = tick_rate() * $urandom_range(0, 5) + $urandom_range(0, 3);
      default: step = $urandom_range(0, 100000);
    endcase
    return step[TickW-1:0];
  endfunction

  task automatic advance_cursor();
    tick_cursor = tick_cursor + tick_step();
  endtask

  task automatic queue_random_mix(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    logic [63:0] wide;
    target = samples_made + count;
    while (samples_made < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) tick_cursor = time_anchor - $urandom_range(0, 40);
      if (pick < 60) begin
        // Press, maybe confirm by interrupt, then release and watch the hold.
        advance_cursor();
        repeat ($urandom_range(1, 5)) begin
          queue_sample(KindPoll, 1'b1, tick_cursor);
          advance_cursor();
        end
        if ($urandom_range(0, 4) == 0) begin
          queue_sample(KindIrq, 1'b1, tick_cursor);
          advance_cursor();
        end
        repeat ($urandom_range(1, 4)) begin
          queue_sample(KindPoll, 1'b0, tick_cursor);
          advance_cursor();
        end
      end else if (pick < 80) begin
        wide = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0) wide = tick_cursor + $urandom_range(0, 1000);
        queue_sample(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                     wide[TickW-1:0]);
      end else if (pick < 90) begin
        queue_sample(KindIrq, logic'($urandom_range(0, 1)), tick_cursor);
        advance_cursor();
      end else if ($urandom_range(0, 1) == 0) begin
        // Time running backwards.
        tick_cursor = tick_cursor - tick_step();
        queue_sample(KindPoll, logic'($urandom_range(0, 1)), tick_cursor);
      end else begin
        // Interrupt that finds the button already up in the middle of a press.
        queue_sample(KindPoll, 1'b1, tick_cursor);
        advance_cursor();
        queue_sample(KindIrq, 1'b0, tick_cursor);
        advance_cursor();
        queue_sample(KindPoll, 1'b1, tick_cursor);
      end
    end
  endtask

  task automatic run_setting(input logic [CfgW-1:0] qualify, input logic [CfgW-1:0] hold,
                             input logic [CfgW-1:0] rate, input logic [ApbW-1:0] minutes_word,
                             input logic [ApbW-1:0] start_word, input int unsigned count);
    logic [63:0] fire_at;
    wait_for_drain();
    write_reg(RegQualify, {$urandom, qualify});
    write_reg(RegHold, {$urandom, hold});
    write_reg(RegTickRate, {$urandom, rate});
    write_reg(RegDemoMin, minutes_word);
    write_reg(RegStartTime, start_word);
    settings_run++;
    fire_at = demo_start_tick();
    time_anchor = fire_at[63] ? MaxTick : fire_at[TickW-1:0];
    tick_cursor = shadow_cfg.start_time;
    // The sender goes quiet halfway until every pending result has come back.
    queue_random_mix(count / 2);
    wait_for_drain();
    queue_random_mix(count - count / 2);
    wait_for_drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    button_in.valid = 1'b0;
    button_in.kind = KindPoll;
    button_in.button_down = 1'b0;
    button_in.now_ticks = '0;
    report_out.ready = 1'b0;
    shadow_cfg.qualify_ticks = QualifyReset;
    shadow_cfg.release_hold_ticks = HoldReset;
    shadow_cfg.ticks_per_second = TickRateReset;
    shadow_cfg.demo_minutes = '0;
    shadow_cfg.start_time = '0;
    held_down = 1'b0;
    shown_pressed = 1'b0;
    release_stamp = '0;
    press_stamp = '0;
    tick_cursor = '0;
    time_anchor = '0;
    samples_made = 0;
    polls_sent = 0;
    irqs_sent = 0;
    demo_polls = 0;
    reports_checked = 0;
    reg_writes = 0;
    settings_run = 1;
    error_count = 0;
    cycle_count = 0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = StallNone;
    stall_mode_left = 0;
    stall_run = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: qualify window edges, hold edges, re-press during hold,
    // backward time, release stamped zero, interrupts and extreme stamps.
    queue_sample(KindPoll, 1'b0, 0);
    queue_sample(KindPoll, 1'b1, 100);
    queue_sample(KindPoll, 1'b1, 50);
    queue_sample(KindPoll, 1'b1, 100 + QualifyReset);
    queue_sample(KindPoll, 1'b1, 101 + QualifyReset);
    queue_sample(KindPoll, 1'b0, 10000);
    queue_sample(KindPoll, 1'b0, 9000);
    queue_sample(KindPoll, 1'b0, 9999 + HoldReset);
    queue_sample(KindPoll, 1'b1, 10000 + HoldReset);
    queue_sample(KindPoll, 1'b0, 10001 + HoldReset);
    queue_sample(KindPoll, 1'b0, 10001 + 2 * HoldReset);
    queue_sample(KindIrq, 1'b1, 4 * HoldReset);
    queue_sample(KindPoll, 1'b0, 0);
    queue_sample(KindPoll, 1'b0, 5);
    queue_sample(KindIrq, 1'b0, MaxTick);
    queue_sample(KindPoll, 1'b1, MaxTick);
    queue_sample(KindPoll, 1'b1, 0);
    queue_sample(KindIrq, 1'b1, 7);
    queue_sample(KindPoll, 1'b1, 8);
    queue_sample(KindPoll, 1'b0, MaxTick);
    queue_sample(KindPoll, 1'b0, 123);
    wait_for_drain();

    // Demo mode with a zero tick rate, which counts as one tick per second.
    write_reg(RegTickRate, 64'd0);
    write_reg(RegDemoMin, 64'd1);
    write_reg(RegStartTime, 64'd0);
    settings_run++;
    queue_sample(KindPoll, 1'b0, 60);
    queue_sample(KindPoll, 1'b0, 61);
    queue_sample(KindPoll, 1'b0, 62);

    run_setting(32'd100, 32'd1000, 32'd50, 64'd0, 64'd0, 400);
    run_setting(32'd0, 32'd0, 32'd1, {$urandom, $urandom} & ~64'h3F,
                {$urandom, $urandom}, 250);
    run_setting(32'd37, 32'd500, 32'd5, ({$urandom, $urandom} & ~64'h3F) | 64'd2,
                {32'd0, $urandom} << 8, 400);
    run_setting('1, '1, '1, '1, 64'd0, 250);
    run_setting(32'd20, 32'd300, 32'd3, 64'd1, '1, 200);
    wait_for_drain();
    write_reg(RegBeyondMap, {$urandom, $urandom});
    write_reg(RegTopUnused, {$urandom, $urandom});
    run_setting(32'd500, 32'd5000, 32'd100, 64'd0, 64'd0, 450);

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d results: %0d polls (%0d with demo toggling) and %0d interrupts.",
             reports_checked, polls_sent, demo_polls, irqs_sent);
    $display("Register writes: %0d over %0d settings; mismatches: %0d.",
             reg_writes, settings_run, error_count);
    if (error_count == 0 && reports_due.size() == 0) begin
      $display("reset_button_qualifier_top test passed");
    end else begin
      $display("reset_button_qualifier_top test failed");
    end
    $finish;
  end

endmodule
